>>> rtl/fbfl_pkg.sv
// Shared types and constants for the fixed block free list allocator.
// No dependencies; fbfl_ctrl, fbfl_dp and the top level import this package.
package fbfl_pkg;

	// Fixed field widths of the request, result and register ports
	localparam int INDEX_W  = 10;
	localparam int OFFSET_W = 26;
	localparam int BYTES_W  = 16;
	localparam int POOL_W   = 11;
	localparam int STRIDE_W = BYTES_W + 1;
	localparam int CFG_W    = BYTES_W;

	// Configuration register indexes
	localparam logic REG_BLOCK_BYTES = 1'b0;
	localparam logic REG_POOL_BLOCKS = 1'b1;

	// Reset values of the configuration registers
	localparam logic [BYTES_W-1:0] BLOCK_BYTES_RST = 16'd4;
	localparam logic [POOL_W-1:0]  POOL_BLOCKS_RST = 11'd10;

	typedef enum logic [1:0] {
		ACT_INIT  = 2'd0,
		ACT_ALLOC = 2'd1,
		ACT_FREE  = 2'd2,
		ACT_RSVD  = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		ST_ALLOCATED = 3'd0,
		ST_EMPTY     = 3'd1,
		ST_FREED     = 3'd2,
		ST_NULL      = 3'd3,
		ST_INIT      = 3'd4,
		ST_BAD       = 3'd5
	} status_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic    init_load;
		logic    init_write;
		logic    init_commit;
		logic    alloc_issue;
		logic    alloc_commit;
		logic    free_commit;
		logic    emit;
		status_t code;
	} cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic head_valid;
		logic bad_index;
		logic limit_zero;
		logic init_last;
	} sts_t;

endpackage

>>> rtl/fbfl_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module fbfl_ram #(
	parameter int WIDTH = 11,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/fbfl_ctrl.sv
// Controller of the free list allocator: sequences init, allocate and free.
// Depends on fbfl_pkg for command, status and code types.
module fbfl_ctrl
	import fbfl_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [1:0] action,
	input  logic       block_present,
	input  sts_t       sts,
	output cmd_t       cmd,
	output logic       busy
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_INIT,
		S_ALLOC
	} state_t;

	state_t state_q;
	state_t state_d;

	// Decode the request and the walk into datapath commands
	always_comb begin
		cmd     = '0;
		cmd.code = ST_BAD;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					unique case (action_t'(action))
						ACT_INIT: begin
							cmd.init_load = 1'b1;
							state_d       = S_INIT;
						end
						ACT_ALLOC: begin
							if (sts.head_valid) begin
								cmd.alloc_issue = 1'b1;
								state_d         = S_ALLOC;
							end else begin
								cmd.emit = 1'b1;
								cmd.code = ST_EMPTY;
							end
						end
						ACT_FREE: begin
							cmd.emit = 1'b1;
							priority if (!block_present) begin
								cmd.code = ST_NULL;
							end else if (sts.bad_index) begin
								cmd.code = ST_BAD;
							end else begin
								cmd.free_commit = 1'b1;
								cmd.code        = ST_FREED;
							end
						end
						ACT_RSVD: begin
							cmd.emit = 1'b1;
							cmd.code = ST_BAD;
						end
					endcase
				end
			end
			S_INIT: begin
				cmd.init_write = !sts.limit_zero;
				if (sts.limit_zero || sts.init_last) begin
					cmd.init_commit = 1'b1;
					cmd.emit        = 1'b1;
					cmd.code        = ST_INIT;
					state_d         = S_IDLE;
				end
			end
			S_ALLOC: begin
				cmd.alloc_commit = 1'b1;
				cmd.emit         = 1'b1;
				cmd.code         = ST_ALLOCATED;
				state_d          = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);

endmodule

>>> rtl/fbfl_dp.sv
// Datapath of the free list allocator: config, head, link memory, offset, result.
// Depends on fbfl_pkg and fbfl_ram.
module fbfl_dp
	import fbfl_pkg::*;
#(
	parameter int MAX_BLOCKS   = 1024,
	parameter int HEADER_BYTES = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	input  logic                cfg_index,
	input  logic [CFG_W-1:0]    cfg_data,
	input  logic [INDEX_W-1:0]  block_index,
	input  cmd_t                cmd,
	output sts_t                sts,
	output logic                done,
	output logic [2:0]          status,
	output logic [INDEX_W-1:0]  granted_index,
	output logic [OFFSET_W-1:0] granted_offset
);

	// Link memory holds at most as many entries as the index field can name
	localparam int DEPTH  = (MAX_BLOCKS < (1 << INDEX_W)) ? MAX_BLOCKS : (1 << INDEX_W);
	localparam int AW     = $clog2(DEPTH);
	localparam int LW     = $clog2(DEPTH + 1);
	localparam int LINK_W = AW + 1;
	localparam int PW     = AW + STRIDE_W;

	logic [BYTES_W-1:0]  block_bytes_q;
	logic [POOL_W-1:0]   pool_blocks_q;
	logic [AW-1:0]       head_q;
	logic                head_valid_q;
	logic [LW-1:0]       live_q;
	logic [LW-1:0]       limit_q;
	logic [LW-1:0]       limit_d;
	logic [AW-1:0]       cnt_q;
	logic [PW-1:0]       prod_q;
	logic [STRIDE_W-1:0] stride;
	logic                done_q;
	status_t             status_q;
	logic [INDEX_W-1:0]  index_q;
	logic [OFFSET_W-1:0] offset_q;

	logic                mem_we;
	logic [AW-1:0]       mem_waddr;
	logic [LINK_W-1:0]   mem_wdata;
	logic [LINK_W-1:0]   mem_rdata;
	logic [LINK_W-1:0]   init_link;
	logic [LINK_W-1:0]   head_link;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_bytes_q <= BLOCK_BYTES_RST;
			pool_blocks_q <= POOL_BLOCKS_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_BLOCK_BYTES: block_bytes_q <= cfg_data;
				REG_POOL_BLOCKS: pool_blocks_q <= cfg_data[POOL_W-1:0];
			endcase
		end
	end

	// Clamp the pool size to the link memory
	assign limit_d = (pool_blocks_q > POOL_W'(DEPTH)) ? LW'(DEPTH) : LW'(pool_blocks_q);

	// Link written by the init walk and by a free
	assign init_link = (cnt_q == '0) ? '0 : {1'b1, cnt_q - AW'(1)};
	assign head_link = head_valid_q ? {1'b1, head_q} : '0;

	assign mem_we    = cmd.init_write | cmd.free_commit;
	assign mem_waddr = cmd.init_write ? cnt_q : block_index[AW-1:0];
	assign mem_wdata = cmd.init_write ? init_link : head_link;

	fbfl_ram #(
		.WIDTH (LINK_W),
		.DEPTH (DEPTH)
	) u_link_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (head_q),
		.rdata (mem_rdata)
	);

	// Head, live count and init walk counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q       <= '0;
			head_valid_q <= 1'b0;
			live_q       <= '0;
			limit_q      <= '0;
			cnt_q        <= '0;
		end else begin
			if (cmd.init_load) begin
				limit_q <= limit_d;
				cnt_q   <= '0;
			end
			if (cmd.init_write) begin
				cnt_q <= cnt_q + AW'(1);
			end
			priority if (cmd.init_commit) begin
				live_q       <= limit_q;
				head_valid_q <= (limit_q != '0);
				head_q       <= (limit_q != '0) ? AW'(limit_q - LW'(1)) : '0;
			end else if (cmd.alloc_commit) begin
				head_valid_q <= mem_rdata[AW];
				head_q       <= mem_rdata[AW-1:0];
			end else if (cmd.free_commit) begin
				head_valid_q <= 1'b1;
				head_q       <= block_index[AW-1:0];
			end
		end
	end

	// Offset product of the block being handed out
	assign stride = STRIDE_W'(block_bytes_q) + STRIDE_W'(HEADER_BYTES);

	always_ff @(posedge clk) begin
		if (cmd.alloc_issue) begin
			prod_q <= PW'(head_q) * PW'(stride);
		end
	end

	// Result register: strobe for one cycle per request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			status_q <= cmd.code;
			if (cmd.alloc_commit) begin
				index_q  <= INDEX_W'(head_q);
				offset_q <= OFFSET_W'(prod_q + PW'(HEADER_BYTES));
			end else begin
				index_q  <= '0;
				offset_q <= '0;
			end
		end
	end

	// Status to the controller
	assign sts.head_valid = head_valid_q;
	assign sts.bad_index  = ({1'b0, block_index} >= POOL_W'(live_q));
	assign sts.limit_zero = (limit_q == '0);
	assign sts.init_last  = ((LW'(cnt_q) + LW'(1)) == limit_q);

	assign done           = done_q;
	assign status         = status_q;
	assign granted_index  = index_q;
	assign granted_offset = offset_q;

endmodule

>>> rtl/fixed_block_free_list_allocator.sv
// Fixed-size block pool allocator kept as a linked free list (top level).
// A request is taken when start is high and busy is low. Free, null free, bad index,
// empty allocate and the unused action finish in the cycle they are taken, so the next
// request can follow at once. Allocate goes on through an S_ALLOC state: the next link
// of the head comes out of the link memory's registered read port. Init walks n =
// min(pool_blocks, depth) links, one link written per cycle through the single write
// port; an empty pool writes none. The result shows on status, granted_index and
// granted_offset for exactly one cycle with done high, in the cycle after the request's
// last cycle; the receiver cannot stall it. The link memory is not cleared after reset:
// before the first init the pool reads as empty.
// Depends on fbfl_pkg, fbfl_ctrl, fbfl_dp and fbfl_ram.
module fixed_block_free_list_allocator
	import fbfl_pkg::*;
#(
	parameter int MAX_BLOCKS   = 1024,
	parameter int HEADER_BYTES = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [1:0]          action,
	input  logic                block_present,
	input  logic [INDEX_W-1:0]  block_index,
	output logic                done,
	output logic [2:0]          status,
	output logic [INDEX_W-1:0]  granted_index,
	output logic [OFFSET_W-1:0] granted_offset,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic                cfg_index,
	input  logic [CFG_W-1:0]    cfg_data
);

	cmd_t cmd;
	sts_t sts;

	// Registers are always writable
	assign cfg_ready = 1'b1;

	fbfl_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.action        (action),
		.block_present (block_present),
		.sts           (sts),
		.cmd           (cmd),
		.busy          (busy)
	);

	fbfl_dp #(
		.MAX_BLOCKS   (MAX_BLOCKS),
		.HEADER_BYTES (HEADER_BYTES)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.block_index    (block_index),
		.cmd            (cmd),
		.sts            (sts),
		.done           (done),
		.status         (status),
		.granted_index  (granted_index),
		.granted_offset (granted_offset)
	);

	// Every accepted request either answers next cycle or is still in progress
	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (done || busy))
		else $error("accepted request neither answered nor in progress");

	// Leaving a multi-cycle request always produces its result
	a_finish_result: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("busy dropped without a result");

	// Only an allocation carries an index and offset
	a_zero_payload: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status != ST_ALLOCATED)) |-> ((granted_index == '0) && (granted_offset == '0)))
		else $error("non-allocation result carries index or offset");

endmodule
